// ===== rtl/core/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean smoother package
// Shared widths, default sizes and the reciprocal lookup used for the
// division of the trimmed sum by the count of kept entries.
// ----------------------------------------------------------------------------
package tms_pkg;

   // Fixed widths of the word fields on the ports.
   localparam int CHANNEL_W = 2;
   localparam int SAMPLE_W  = 10;

   // Defaults of the top-level parameters.
   localparam int CHANNELS_DEF    = 4;
   localparam int WINDOW_DEF      = 5;
   localparam int SAMPLE_BITS_DEF = 10;

   // Trimming starts at this many filled entries and drops this many.
   localparam int TRIM_MIN_FILL = 3;
   localparam int TRIM_DROP     = 2;

   // Divisors run from 1 to 6; a 3-bit code covers them.
   localparam int DIVISOR_W = 3;

   // Quotient = (total * recip_of(d)) >> RECIP_SHIFT, with each entry the
   // ceiling of 2^RECIP_SHIFT / d. The shift is large enough to be exact for
   // sums of up to 19 bits and divisors up to 6. A zero divisor never occurs.
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = 23;

   function automatic logic [RECIP_W-1:0] recip_of(input logic [DIVISOR_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         3'd1:    r = 23'd4194304;
         3'd2:    r = 23'd2097152;
         3'd3:    r = 23'd1398102;
         3'd4:    r = 23'd1048576;
         3'd5:    r = 23'd838861;
         3'd6:    r = 23'd699051;
         3'd7:    r = 23'd599187;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/tms_stats.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean smoother window statistics
// Inserts the new sample into the row read from the window memory and forms
// the trimmed sum and the divisor over the filled entries.
// ----------------------------------------------------------------------------
module tms_stats #(
   parameter int WINDOW      = tms_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = tms_pkg::SAMPLE_BITS_DEF
) (
   input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]               row_old,
   input  logic [SAMPLE_BITS-1:0]                           sample,
   input  logic [$clog2(WINDOW)-1:0]                        pos,
   input  logic [$clog2(WINDOW+1)-1:0]                      fill,
   output logic [WINDOW-1:0][SAMPLE_BITS-1:0]               row_new,
   output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]            total,
   output logic [tms_pkg::DIVISOR_W-1:0]                    divisor
);
   import tms_pkg::*;

   localparam int POS_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW+1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);

   logic [SUM_W-1:0]       sum;
   logic [SAMPLE_BITS-1:0] min_val;
   logic [SAMPLE_BITS-1:0] max_val;

   // The new sample replaces the entry at the write position.
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         row_new[i] = (POS_W'(i) == pos) ? sample : row_old[i];
      end
   end

   // Sum, minimum and maximum over the filled entries only.
   always_comb begin
      sum     = '0;
      min_val = '1;
      max_val = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (FILL_W'(i) < fill) begin
            sum = sum + SUM_W'(row_new[i]);
            if (row_new[i] < min_val) begin
               min_val = row_new[i];
            end
            if (row_new[i] > max_val) begin
               max_val = row_new[i];
            end
         end
      end
   end

   // With enough entries the extremes are dropped from the sum and the count.
   always_comb begin
      if (fill >= FILL_W'(TRIM_MIN_FILL)) begin
         total   = sum - SUM_W'(min_val) - SUM_W'(max_val);
         divisor = DIVISOR_W'(fill - FILL_W'(TRIM_DROP));
      end else begin
         total   = sum;
         divisor = DIVISOR_W'(fill);
      end
   end

endmodule

// ===== rtl/core/trimmed_mean_smoother.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean smoother
// Keeps a ring window of recent samples per channel in a row-wide memory and
// returns, for each sample word, the mean of the channel's filled entries
// with the minimum and maximum dropped once three or more are present.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_channel, req_sample
//   rsp_      out        rsp_valid / rsp_stall  rsp_channel_out, rsp_smoothed
//
// The memory row is read at acceptance, merge and trim follow in the merge
// state, and the reciprocal multiply loads the result register from the
// multiply state. A new word can be accepted while the previous one is in
// the multiply stage but not during its merge; the window memory's
// read-merge-write of one row sets that limit.
// Reset is synchronous and clears the per-channel write positions and fill
// counts; the window memory holds no reset value and needs no clearing.
// A stalled result word holds the multiply stage, which in turn stalls input.
// ----------------------------------------------------------------------------
module trimmed_mean_smoother #(
   parameter int CHANNELS    = tms_pkg::CHANNELS_DEF,
   parameter int WINDOW      = tms_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = tms_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tms_pkg::CHANNEL_W-1:0]  req_channel,
   input  logic [tms_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tms_pkg::CHANNEL_W-1:0]  rsp_channel_out,
   output logic [tms_pkg::SAMPLE_W-1:0]   rsp_smoothed
);
   import tms_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW+1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int PROD_W = SUM_W + RECIP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DIV
   } state_type;

   typedef logic [WINDOW-1:0][SAMPLE_BITS-1:0] row_type;

   state_type state_ff;

   // Window memory, one row per channel, and the per-channel ring state.
   row_type           win_mem [CHANNELS];
   row_type           rd_row_ff;
   logic [POS_W-1:0]  pos_ff  [CHANNELS];
   logic [FILL_W-1:0] fill_ff [CHANNELS];

   // Word in flight.
   logic [CHANNEL_W-1:0]   item_ch_ff;
   logic                   item_ok_ff;
   logic [SAMPLE_BITS-1:0] item_sample_ff;
   logic [POS_W-1:0]       item_pos_ff;
   logic [FILL_W-1:0]      item_fill_ff;
   logic [SUM_W-1:0]       total_ff;
   logic [DIVISOR_W-1:0]   divisor_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic [CHANNEL_W-1:0] rsp_channel_ff;
   logic [SAMPLE_W-1:0]  rsp_smoothed_ff;

   logic                 req_accept;
   logic                 out_free;
   logic                 in_range;
   logic [CH_W-1:0]      ch_idx;
   logic [CH_W-1:0]      item_idx;
   logic [POS_W-1:0]     pos_cur;
   logic [FILL_W-1:0]    fill_cur;
   logic [POS_W-1:0]     pos_in;
   logic [FILL_W-1:0]    fill_in;
   row_type              row_in;
   logic [SUM_W-1:0]     total_in;
   logic [DIVISOR_W-1:0] divisor_in;
   logic [PROD_W-1:0]    prod;
   logic [SAMPLE_W-1:0]  smoothed_in;

   // Handshake: the merge cycle never takes a word, and the multiply stage
   // only hands over when the result register can take its word.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff == ST_MERGE) || ((state_ff == ST_DIV) && !out_free);
   assign req_accept = req_valid && !req_stall;

   // Channel lookup and ring advance for the incoming word.
   assign in_range = int'(req_channel) < CHANNELS;
   assign ch_idx   = CH_W'(req_channel);
   assign item_idx = CH_W'(item_ch_ff);
   assign pos_cur  = pos_ff[ch_idx];
   assign fill_cur = fill_ff[ch_idx];
   assign pos_in   = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + POS_W'(1);
   assign fill_in  = (fill_cur == FILL_W'(WINDOW)) ? fill_cur : fill_cur + FILL_W'(1);

   tms_stats #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_stats (
      .row_old (rd_row_ff),
      .sample  (item_sample_ff),
      .pos     (item_pos_ff),
      .fill    (item_fill_ff),
      .row_new (row_in),
      .total   (total_in),
      .divisor (divisor_in)
   );

   // Division by the kept count as a multiply by its reciprocal.
   assign prod        = PROD_W'(total_ff) * PROD_W'(recip_of(divisor_ff));
   assign smoothed_in = item_ok_ff ? prod[RECIP_SHIFT +: SAMPLE_W] : '0;

   // Window memory: row read at acceptance, merged row written back next cycle.
   always_ff @(posedge clock) begin
      if (req_accept && in_range) begin
         rd_row_ff <= win_mem[ch_idx];
      end
      if ((state_ff == ST_MERGE) && item_ok_ff) begin
         win_mem[item_idx] <= row_in;
      end
   end

   // Per-channel write position and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i]  <= '0;
            fill_ff[i] <= '0;
         end
      end else if (req_accept && in_range) begin
         pos_ff[ch_idx]  <= pos_in;
         fill_ff[ch_idx] <= fill_in;
      end
   end

   // Payload of the word in flight.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ch_ff     <= req_channel;
         item_ok_ff     <= in_range;
         item_sample_ff <= SAMPLE_BITS'(req_sample);
         item_pos_ff    <= pos_cur;
         item_fill_ff   <= fill_in;
      end
      if (state_ff == ST_MERGE) begin
         total_ff   <= total_in;
         divisor_ff <= divisor_in;
      end
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A taken result word clears the flag unless the multiply stage
         // hands over the next one in the same cycle.
         if (!rsp_stall && (state_ff != ST_DIV)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_MERGE;
               end
            end
            ST_MERGE: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_channel_ff  <= item_ch_ff;
                  rsp_smoothed_ff <= smoothed_in;
                  state_ff        <= req_accept ? ST_MERGE : ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_smoothed    = rsp_smoothed_ff;

`ifndef SYNTHESIS
   // An accepted word always moves on to the merge cycle.
   a_accept_to_merge: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_MERGE)
      else $error("accepted word did not enter the merge cycle");

   // The merge cycle is always followed by the multiply stage.
   a_merge_to_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |=> state_ff == ST_DIV)
      else $error("merge cycle not followed by the multiply stage");

   // A blocked multiply stage holds its word.
   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && !out_free |=> state_ff == ST_DIV)
      else $error("multiply stage dropped a word while blocked");

   // A fresh result word only comes out of the multiply stage.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DIV)
      else $error("result word appeared outside the multiply stage");

   // The fill count of a looked-up channel never passes the window depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      req_accept && in_range |-> fill_cur <= FILL_W'(WINDOW))
      else $error("fill count exceeds the window depth");
`endif

endmodule
